/* hw/rtl/smab_pkg.sv */
// ----------------------------------------------------------------------------
// Serial memory access bridge package
// Shared types and constants for the serial-to-bus bridge and its parser.
// ----------------------------------------------------------------------------
package smab_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'h11;
  localparam logic [7:0] CMD_WRITE = 8'h00;
  localparam logic [7:0] CMD_READ  = 8'h01;
  localparam logic [7:0] CMD_BOOT  = 8'h02;

  localparam logic [2:0] KIND_STORE_WORD = 3'd0;
  localparam logic [2:0] KIND_STORE_BYTE = 3'd1;
  localparam logic [2:0] KIND_LOAD_WORD  = 3'd2;
  localparam logic [2:0] KIND_LOAD_BYTE  = 3'd3;
  localparam logic [2:0] KIND_SEND_BYTE  = 3'd4;
  localparam logic [2:0] KIND_BOOT_JUMP  = 3'd5;

  typedef enum logic [2:0] {
    PH_SYNC,
    PH_CMD,
    PH_ADDR,
    PH_LEN,
    PH_WDATA,
    PH_RWAIT
  } phase_t;

  // Results caused by one request: optional send bytes, then an optional
  // bus operation.
  typedef struct packed {
    logic [2:0]  count;
    logic        has_send;
    logic        send_word;
    logic [31:0] send_data;
    logic        has_op;
    logic [2:0]  op_kind;
    logic [31:0] op_addr;
    logic [31:0] op_data;
  } batch_t;

endpackage

/* hw/rtl/smab_parser.sv */
// ----------------------------------------------------------------------------
// Serial memory access bridge parser
// Holds the command state and turns one request into a batch of results.
// ----------------------------------------------------------------------------
module smab_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            action,
  input  logic [7:0]      rx_byte,
  input  logic [31:0]     read_data,
  output smab_pkg::batch_t batch
);
  import smab_pkg::*;

  phase_t      phase;
  phase_t      phase_next;
  logic [1:0]  command;
  logic [1:0]  command_next;
  logic [2:0]  byte_count;
  logic [2:0]  byte_count_next;
  logic [31:0] cur_address;
  logic [31:0] cur_address_next;
  logic [15:0] remaining;
  logic [15:0] remaining_next;
  logic [31:0] assembly_word;
  logic [31:0] assembly_word_next;
  logic        pending_is_word;
  logic        pending_is_word_next;

  logic [2:0]  bc_inc;
  logic [2:0]  step_sz;
  logic [31:0] addr_adv;
  logic [15:0] rem_adv;
  logic [31:0] addr_val;
  logic [15:0] len_val;
  logic [31:0] asm_val;
  logic        word_after_adv;
  logic        word_len;
  logic        cmd_valid;

  assign bc_inc         = byte_count + 3'd1;
  assign step_sz        = pending_is_word ? 3'd4 : 3'd1;
  assign addr_adv       = cur_address + {29'd0, step_sz};
  assign rem_adv        = remaining - {13'd0, step_sz};
  assign addr_val       = cur_address | ({24'd0, rx_byte} << {byte_count[1:0], 3'b000});
  assign len_val        = remaining | ({8'd0, rx_byte} << {byte_count[0], 3'b000});
  assign asm_val        = assembly_word | ({24'd0, rx_byte} << {byte_count[1:0], 3'b000});
  assign word_after_adv = (addr_adv[1:0] == 2'd0) && (rem_adv >= 16'd4);
  assign word_len       = (cur_address[1:0] == 2'd0) && (len_val >= 16'd4);
  assign cmd_valid      = rx_byte inside {CMD_WRITE, CMD_READ, CMD_BOOT};

  always_comb begin
    phase_next = phase;
    case (phase)
      PH_SYNC: begin
        if (!action && rx_byte == SYNC_BYTE) phase_next = PH_CMD;
      end
      PH_CMD: begin
        if (!action) phase_next = cmd_valid ? PH_ADDR : PH_SYNC;
      end
      PH_ADDR: begin
        if (!action && bc_inc[2]) begin
          phase_next = (command == CMD_BOOT[1:0]) ? PH_SYNC : PH_LEN;
        end
      end
      PH_LEN: begin
        if (!action && (bc_inc[2] || bc_inc[1])) begin
          if (len_val == 16'd0) phase_next = PH_SYNC;
          else if (command == CMD_READ[1:0]) phase_next = PH_RWAIT;
          else phase_next = PH_WDATA;
        end
      end
      PH_WDATA: begin
        if (!action && (!pending_is_word || bc_inc[2]) && rem_adv == 16'd0) begin
          phase_next = PH_SYNC;
        end
      end
      PH_RWAIT: begin
        if (action && rem_adv == 16'd0) phase_next = PH_SYNC;
      end
      default: phase_next = PH_SYNC;
    endcase
  end

  always_comb begin
    command_next         = command;
    byte_count_next      = byte_count;
    cur_address_next     = cur_address;
    remaining_next       = remaining;
    assembly_word_next   = assembly_word;
    pending_is_word_next = pending_is_word;
    batch                = '0;
    if (action) begin
      if (phase == PH_RWAIT) begin
        batch.has_send   = 1'b1;
        batch.send_word  = pending_is_word;
        batch.send_data  = read_data;
        cur_address_next = addr_adv;
        remaining_next   = rem_adv;
        if (rem_adv != 16'd0) begin
          pending_is_word_next = word_after_adv;
          byte_count_next      = 3'd0;
          assembly_word_next   = 32'd0;
          batch.has_op         = 1'b1;
          batch.op_kind        = word_after_adv ? KIND_LOAD_WORD : KIND_LOAD_BYTE;
          batch.op_addr        = addr_adv;
        end
      end
    end else begin
      case (phase)
        PH_CMD: begin
          if (cmd_valid) begin
            command_next     = rx_byte[1:0];
            byte_count_next  = 3'd0;
            cur_address_next = 32'd0;
          end
        end
        PH_ADDR: begin
          cur_address_next = addr_val;
          byte_count_next  = bc_inc;
          if (bc_inc[2]) begin
            byte_count_next = 3'd0;
            if (command == CMD_BOOT[1:0]) begin
              batch.has_op  = 1'b1;
              batch.op_kind = KIND_BOOT_JUMP;
              batch.op_addr = addr_val;
            end else begin
              remaining_next = 16'd0;
            end
          end
        end
        PH_LEN: begin
          remaining_next  = len_val;
          byte_count_next = bc_inc;
          if (bc_inc[2] || bc_inc[1]) begin
            byte_count_next = 3'd0;
            if (len_val != 16'd0) begin
              pending_is_word_next = word_len;
              assembly_word_next   = 32'd0;
              if (command == CMD_READ[1:0]) begin
                batch.has_op  = 1'b1;
                batch.op_kind = word_len ? KIND_LOAD_WORD : KIND_LOAD_BYTE;
                batch.op_addr = cur_address;
              end
            end
          end
        end
        PH_WDATA: begin
          if (pending_is_word) begin
            assembly_word_next = asm_val;
            byte_count_next    = bc_inc;
          end
          if (!pending_is_word || bc_inc[2]) begin
            batch.has_op     = 1'b1;
            batch.op_kind    = pending_is_word ? KIND_STORE_WORD : KIND_STORE_BYTE;
            batch.op_addr    = cur_address;
            batch.op_data    = pending_is_word ? asm_val : {24'd0, rx_byte};
            cur_address_next = addr_adv;
            remaining_next   = rem_adv;
            if (rem_adv != 16'd0) begin
              pending_is_word_next = word_after_adv;
              byte_count_next      = 3'd0;
              assembly_word_next   = 32'd0;
            end
          end
        end
        default: begin
        end
      endcase
    end
    batch.count = (batch.has_send ? (batch.send_word ? 3'd4 : 3'd1) : 3'd0)
                  + {2'd0, batch.has_op};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SYNC;
      command         <= 2'd0;
      byte_count      <= 3'd0;
      cur_address     <= 32'd0;
      remaining       <= 16'd0;
      assembly_word   <= 32'd0;
      pending_is_word <= 1'b0;
    end else if (en) begin
      phase           <= phase_next;
      command         <= command_next;
      byte_count      <= byte_count_next;
      cur_address     <= cur_address_next;
      remaining       <= remaining_next;
      assembly_word   <= assembly_word_next;
      pending_is_word <= pending_is_word_next;
    end
  end

endmodule

/* hw/rtl/serial_memory_access_bridge_unit.sv */
// ----------------------------------------------------------------------------
// Serial memory access bridge
// Parses serial command bytes and bus load returns into bus operations and
// bytes to transmit.
// ----------------------------------------------------------------------------
// A request is taken in every cycle unless results are backed up. Each request
// passes an input register, is parsed into a batch of zero to five results,
// and its results leave the output register one per cycle unless the output
// stalls, the first once the batch is loaded into the output register. A load
// return with a word load outstanding causes four send bytes and possibly the
// next load, so it holds the output register for up to five results; requests
// with no result never wait for the output side.
module serial_memory_access_bridge_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  rx_byte,
  input  logic [31:0] read_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [31:0] bus_address,
  output logic [31:0] bus_data,
  output logic [7:0]  tx_byte,
  output logic        last
);
  import smab_pkg::*;

  logic        s1_valid;
  logic        s1_action;
  logic [7:0]  s1_rx_byte;
  logic [31:0] s1_read_data;

  batch_t      nb;
  batch_t      b;
  logic        b_valid;
  logic [2:0]  pos;

  logic        adv;
  logic        out_acc;
  logic        b_done;
  logic        in_acc;
  logic        in_send;
  logic [31:0] send_shift;

  assign out_acc  = b_valid && !out_stall;
  assign b_done   = out_acc && last;
  assign adv      = s1_valid && (!b_valid || b_done || nb.count == 3'd0);
  assign in_stall = s1_valid && !adv;
  assign in_acc   = in_valid && !in_stall;

  smab_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .action    (s1_action),
    .rx_byte   (s1_rx_byte),
    .read_data (s1_read_data),
    .batch     (nb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_action    <= action;
      s1_rx_byte   <= rx_byte;
      s1_read_data <= read_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      pos     <= 3'd0;
    end else if (adv && nb.count != 3'd0) begin
      b_valid <= 1'b1;
      pos     <= 3'd0;
    end else if (b_done) begin
      b_valid <= 1'b0;
      pos     <= 3'd0;
    end else if (out_acc) begin
      pos <= pos + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && nb.count != 3'd0) begin
      b <= nb;
    end
  end

  assign in_send    = b.has_send && (b.send_word ? (pos < 3'd4) : (pos == 3'd0));
  assign send_shift = b.send_data >> {pos[1:0], 3'b000};

  assign out_valid   = b_valid;
  assign kind        = in_send ? KIND_SEND_BYTE : b.op_kind;
  assign bus_address = in_send ? 32'd0 : b.op_addr;
  assign bus_data    = in_send ? 32'd0 : b.op_data;
  assign tx_byte     = in_send ? send_shift[7:0] : 8'd0;
  assign last        = (pos == (b.count - 3'd1));

  a_pos_in_batch: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (pos < b.count))
    else $error("result index beyond batch size");

  a_batch_nonempty: assert property (@(posedge clk) disable iff (rst)
    b_valid |-> (b.count != 3'd0))
    else $error("empty batch held in output register");

  a_batch_release: assert property (@(posedge clk) disable iff (rst)
    (b_done && !(adv && nb.count != 3'd0)) |=> !b_valid)
    else $error("batch not released after its last result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (b_valid && !b_done && adv) |-> (nb.count == 3'd0))
    else $error("new batch loaded over unfinished batch");

endmodule
